FILE: sv/xkfs_pkg.sv
// Shared types, file type codes and the magic signature table for the XOR key search.
`default_nettype none

package xkfs_pkg;

  localparam int KEY_W     = 8;
  localparam int HDR_BYTES = 12;
  localparam int HDR_W     = 8 * HDR_BYTES;
  localparam int SIG_COUNT = 42;

  // File type codes
  localparam logic [4:0] FT_NONE = 5'd0;
  localparam logic [4:0] FT_MP4  = 5'd1;
  localparam logic [4:0] FT_3G2  = 5'd2;
  localparam logic [4:0] FT_MOV  = 5'd3;
  localparam logic [4:0] FT_M4V  = 5'd4;
  localparam logic [4:0] FT_3GP  = 5'd5;
  localparam logic [4:0] FT_PNG  = 5'd6;
  localparam logic [4:0] FT_MKV  = 5'd7;
  localparam logic [4:0] FT_WMV  = 5'd8;
  localparam logic [4:0] FT_AVI  = 5'd9;
  localparam logic [4:0] FT_SVG  = 5'd10;
  localparam logic [4:0] FT_GIF  = 5'd11;
  localparam logic [4:0] FT_WEBM = 5'd12;
  localparam logic [4:0] FT_WEBP = 5'd13;
  localparam logic [4:0] FT_VOB  = 5'd14;
  localparam logic [4:0] FT_MPG  = 5'd15;
  localparam logic [4:0] FT_JPG  = 5'd16;
  localparam logic [4:0] FT_FLV  = 5'd17;
  localparam logic [4:0] FT_BMP  = 5'd18;

  // Above any recorded length, so the entry is never blocked
  localparam logic [3:0] NO_GUARD = 4'd15;

  // pat holds byte 0 in the top byte; mask bit 11 covers byte 0
  typedef struct packed {
    logic [HDR_W-1:0]     pat;
    logic [HDR_BYTES-1:0] mask;
    logic [4:0]           ftype;
    logic [3:0]           len;
    logic [3:0]           guard;
    logic                 stop;
  } sig_entry_t;

  localparam sig_entry_t SIG_TABLE [SIG_COUNT] = '{
    '{96'h00000018_66747970_33677035, 12'hfff, FT_MP4, 4'd12, NO_GUARD, 1'b1},
    '{96'h00000014_66747970_33677035, 12'hfff, FT_MP4, 4'd12, NO_GUARD, 1'b1},
    '{96'h0000001c_66747970_33677035, 12'hfff, FT_MP4, 4'd12, NO_GUARD, 1'b1},
    '{96'h00000018_66747970_4d534e56, 12'hfff, FT_MP4, 4'd12, NO_GUARD, 1'b1},
    '{96'h00000014_66747970_4d534e56, 12'hfff, FT_MP4, 4'd12, NO_GUARD, 1'b1},
    '{96'h0000001c_66747970_4d534e56, 12'hfff, FT_MP4, 4'd12, NO_GUARD, 1'b1},
    '{96'h00000018_66747970_69736f6d, 12'hfff, FT_MP4, 4'd12, NO_GUARD, 1'b1},
    '{96'h00000014_66747970_69736f6d, 12'hfff, FT_MP4, 4'd12, NO_GUARD, 1'b1},
    '{96'h0000001c_66747970_69736f6d, 12'hfff, FT_MP4, 4'd12, NO_GUARD, 1'b1},
    '{96'h0000001c_66747970_33673261, 12'hfff, FT_3G2, 4'd12, NO_GUARD, 1'b1},
    '{96'h00000014_66747970_71742020, 12'hfff, FT_MOV, 4'd12, NO_GUARD, 1'b1},
    '{96'h00000020_66747970_4d345620, 12'hfff, FT_M4V, 4'd12, NO_GUARD, 1'b1},
    '{96'h00000018_66747970_6d703432, 12'hfff, FT_MP4, 4'd12, NO_GUARD, 1'b1},
    '{96'h00000014_66747970_33677000, 12'hffe, FT_3GP, 4'd11, NO_GUARD, 1'b1},
    '{96'h00000018_66747970_00000000, 12'hff0, FT_MP4, 4'd8,  NO_GUARD, 1'b1},
    '{96'h66747970_71742020_00000000, 12'hff0, FT_MOV, 4'd8,  NO_GUARD, 1'b1},
    '{96'h66747970_6d703432_00000000, 12'hff0, FT_M4V, 4'd8,  NO_GUARD, 1'b1},
    '{96'h66747970_69736f6d_00000000, 12'hff0, FT_MP4, 4'd8,  NO_GUARD, 1'b1},
    '{96'h66747970_33677035_00000000, 12'hff0, FT_MP4, 4'd8,  NO_GUARD, 1'b1},
    '{96'h66747970_4d534e56_00000000, 12'hff0, FT_MP4, 4'd8,  NO_GUARD, 1'b1},
    '{96'h89504e47_0d0a1a0a_00000000, 12'hff0, FT_PNG, 4'd8,  NO_GUARD, 1'b1},
    '{96'h1a45dfa3_93428288_00000000, 12'hff0, FT_MKV, 4'd8,  NO_GUARD, 1'b1},
    '{96'h3026b275_8e66cf11_00000000, 12'hff0, FT_WMV, 4'd8,  NO_GUARD, 1'b1},
    '{96'h52494646_00000000_41564920, 12'hf0f, FT_AVI, 4'd8,  NO_GUARD, 1'b0},
    '{96'h3c3f786d_6c200000_00000000, 12'hfc0, FT_SVG, 4'd6,  NO_GUARD, 1'b0},
    '{96'h47494638_39610000_00000000, 12'hfc0, FT_GIF, 4'd6,  NO_GUARD, 1'b0},
    '{96'h47494638_37610000_00000000, 12'hfc0, FT_GIF, 4'd6,  NO_GUARD, 1'b0},
    '{96'h1a45dfa3_00000000_00000000, 12'hf00, FT_WEBM, 4'd4, 4'd4, 1'b0},
    '{96'h52494646_00000000_00000000, 12'hf00, FT_WEBP, 4'd4, 4'd4, 1'b0},
    '{96'h000001ba_00000000_00000000, 12'hf00, FT_VOB, 4'd4,  4'd4, 1'b0},
    '{96'h6d6f6f76_00000000_00000000, 12'hf00, FT_MOV, 4'd4,  4'd4, 1'b0},
    '{96'h66726565_00000000_00000000, 12'hf00, FT_MOV, 4'd4,  4'd4, 1'b0},
    '{96'h6d646174_00000000_00000000, 12'hf00, FT_MOV, 4'd4,  4'd4, 1'b0},
    '{96'h77696465_00000000_00000000, 12'hf00, FT_MOV, 4'd4,  4'd4, 1'b0},
    '{96'h706e6f74_00000000_00000000, 12'hf00, FT_MOV, 4'd4,  4'd4, 1'b0},
    '{96'h736b6970_00000000_00000000, 12'hf00, FT_MOV, 4'd4,  4'd4, 1'b0},
    '{96'h000001b3_00000000_00000000, 12'hf00, FT_MPG, 4'd4,  4'd4, 1'b0},
    '{96'hffd8ffe0_00000000_00000000, 12'hf00, FT_JPG, 4'd4,  4'd4, 1'b0},
    '{96'hffd8ffe1_00000000_00000000, 12'hf00, FT_JPG, 4'd4,  4'd4, 1'b0},
    '{96'hffd8ffe8_00000000_00000000, 12'hf00, FT_JPG, 4'd4,  4'd4, 1'b0},
    '{96'h464c5601_00000000_00000000, 12'hf00, FT_FLV, 4'd4,  4'd4, 1'b0},
    '{96'h424d0000_00000000_00000000, 12'hc00, FT_BMP, 4'd2,  4'd2, 1'b0}
  };

  typedef struct packed {
    logic load;     // capture header, clear the record, key to zero
    logic step;     // try the current key
    logic publish;  // copy the record to the output registers
  } xkfs_cmd_t;

  typedef struct packed {
    logic stop_hit; // current key matched a terminating entry
    logic last_key; // current key is the final one
  } xkfs_status_t;

endpackage

`default_nettype wire

FILE: sv/xkfs_datapath.sv
// Datapath: header register, key counter, signature matcher and search record.
`default_nettype none

module xkfs_datapath
  import xkfs_pkg::*;
#(
  parameter int KEY_COUNT = 256
) (
  input  wire logic               clk,
  input  wire logic [63:0]        header_first_eight,
  input  wire logic [31:0]        header_last_four,
  input  wire xkfs_cmd_t          cmd,
  output xkfs_status_t            stat,
  output logic [4:0]              file_type,
  output logic [KEY_W-1:0]        found_key,
  output logic                    found
);

  localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(KEY_COUNT - 1);

  logic [HDR_W-1:0] hdr;
  logic [KEY_W-1:0] key;
  logic [4:0]       rec_type;
  logic [KEY_W-1:0] rec_key;
  logic [3:0]       rec_len;
  logic             rec_found;

  logic [HDR_W-1:0] dec;
  logic             hit_any;
  sig_entry_t       sel;

  // Byte 0 goes to the top byte, to line up with the table
  function automatic logic [HDR_W-1:0] pack_header(input logic [63:0] first,
                                                   input logic [31:0] last);
    logic [HDR_W-1:0] r;
    r = '0;
    for (int j = 0; j < 8; j++) r[HDR_W-1-8*j -: 8] = first[8*j +: 8];
    for (int j = 0; j < 4; j++) r[31-8*j -: 8] = last[8*j +: 8];
    return r;
  endfunction

  function automatic logic [HDR_W-1:0] byte_mask(input logic [HDR_BYTES-1:0] m);
    logic [HDR_W-1:0] r;
    r = '0;
    for (int j = 0; j < HDR_BYTES; j++) r[HDR_W-1-8*j -: 8] = {8{m[HDR_BYTES-1-j]}};
    return r;
  endfunction

  assign dec = hdr ^ {HDR_BYTES{key}};

  // Walk from the bottom so the first entry in table order wins
  always_comb begin
    hit_any = 1'b0;
    sel     = '0;
    for (int k = SIG_COUNT - 1; k >= 0; k--) begin
      if ((((dec ^ SIG_TABLE[k].pat) & byte_mask(SIG_TABLE[k].mask)) == '0) &&
          (rec_len < SIG_TABLE[k].guard)) begin
        hit_any = 1'b1;
        sel     = SIG_TABLE[k];
      end
    end
  end

  assign stat.stop_hit = hit_any & sel.stop;
  assign stat.last_key = (key == LAST_KEY);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hdr       <= pack_header(header_first_eight, header_last_four);
      key       <= '0;
      rec_type  <= FT_NONE;
      rec_key   <= '0;
      rec_len   <= '0;
      rec_found <= 1'b0;
    end else if (cmd.step) begin
      key <= key + 1'b1;
      if (hit_any) begin
        rec_type  <= sel.ftype;
        rec_len   <= sel.len;
        rec_key   <= key;
        rec_found <= 1'b1;
      end
    end
    if (cmd.publish) begin
      file_type <= rec_type;
      found_key <= rec_key;
      found     <= rec_found;
    end
  end

endmodule

`default_nettype wire

FILE: sv/xkfs_ctrl.sv
// Controller: sequences the key sweep and owns both handshakes.
`default_nettype none

module xkfs_ctrl
  import xkfs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire xkfs_status_t stat,
  output xkfs_cmd_t         cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_HOLD   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;

  assign in_ready    = (state == S_IDLE);
  assign cmd.load    = in_valid & in_ready;
  assign cmd.step    = (state == S_SEARCH);
  // result waits in HOLD until the output register is free
  assign cmd.publish = (state == S_HOLD) & (~out_valid | out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (cmd.load) state_next = S_SEARCH;
      S_SEARCH: if (stat.stop_hit || stat.last_key) state_next = S_HOLD;
      S_HOLD:   if (cmd.publish) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.publish) out_valid_next = 1'b1;
    else if (out_ready)       out_valid_next = 1'b0;
    else                      out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_SEARCH)
    else $error("accepted item did not start the key sweep");

  a_sweep_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH && (stat.stop_hit || stat.last_key)) |=> state == S_HOLD)
    else $error("key sweep ran past its end");

  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> out_valid && state == S_IDLE)
    else $error("published result not presented");

endmodule

`default_nettype wire

FILE: sv/xor_key_file_signature_search_top.sv
// Top level of the XOR key file signature search.
// One item is a 12-byte file header. The block tries keys 0 to KEY_COUNT-1 in turn,
// one key per clock through a single signature matcher, and stops early on the first
// key that hits a terminating signature (ftyp family, png, mkv, wmv). Each item is
// accepted, its keys are tried, and its result is then moved into the output register.
// A finished result waits there while the next header is accepted and searched;
// found_key and file_type are zero when found is low.
`default_nettype none

module xor_key_file_signature_search_top
  import xkfs_pkg::*;
#(
  parameter int KEY_COUNT = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [63:0]       header_first_eight,
  input  wire logic [31:0]       header_last_four,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [4:0]             file_type,
  output logic [KEY_W-1:0]       found_key,
  output logic                   found
);

  xkfs_cmd_t    cmd;
  xkfs_status_t stat;

  xkfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  xkfs_datapath #(
    .KEY_COUNT (KEY_COUNT)
  ) u_datapath (
    .clk                (clk),
    .header_first_eight (header_first_eight),
    .header_last_four   (header_last_four),
    .cmd                (cmd),
    .stat               (stat),
    .file_type          (file_type),
    .found_key          (found_key),
    .found              (found)
  );

endmodule

`default_nettype wire
